// File: design/playfair_pair_cipher_top_macros.svh
// assertion macros for the playfair pair cipher block
// used by modules that carry concurrent checks; no other dependencies
`ifndef PLAYFAIR_PAIR_CIPHER_TOP_MACROS_SVH
`define PLAYFAIR_PAIR_CIPHER_TOP_MACROS_SVH

// implication in the same cycle
`define PPC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle
`define PPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/ppc_pkg.sv
// shared types, letter constants and helper functions of the playfair block
// no dependencies
package ppc_pkg;

  localparam int LetterW = 5;
  typedef logic [LetterW-1:0] letter_t;
  typedef logic [2:0]         coord_t;

  // input item codes
  localparam logic [1:0] FUNC_KEY  = 2'd0;
  localparam logic [1:0] FUNC_FILL = 2'd1;
  localparam logic [1:0] FUNC_PAIR = 2'd2;

  localparam letter_t LETTER_I    = 5'd8;
  localparam letter_t LETTER_J    = 5'd9;
  localparam letter_t LETTER_X    = 5'd23;
  localparam letter_t LETTER_Z    = 5'd25;
  localparam letter_t SQUARE_SIZE = 5'd25;
  localparam int      NumLetters  = 26;
  localparam int      SquareCells = 25;
  localparam coord_t  GRID_LAST   = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic place_key;
    logic fill_start;
    logic fill_step;
    logic set_ready;
    logic capture;
    logic pos_read;
    logic sq_read;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic square_ready;
    logic fill_last;
  } dp_status_t;

  // saturate to z, then fold j onto i
  function automatic letter_t fold_letter(letter_t v);
    letter_t c;
    c = (v > LETTER_Z) ? LETTER_Z : v;
    if (c == LETTER_J) c = LETTER_I;
    return c;
  endfunction

  function automatic coord_t pos_row(letter_t p);
    coord_t r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  function automatic coord_t pos_col(letter_t p);
    letter_t base;
    base = letter_t'(pos_row(p)) * letter_t'(5);
    return coord_t'(p - base);
  endfunction

  // one step along a row or column with wrap, forward or backward
  function automatic coord_t coord_step(coord_t v, logic dec);
    coord_t n;
    if (dec) n = (v == 3'd0) ? GRID_LAST : v - 3'd1;
    else     n = (v == GRID_LAST) ? 3'd0 : v + 3'd1;
    return n;
  endfunction

  function automatic letter_t grid_addr(coord_t row, coord_t col);
    return letter_t'(row) * letter_t'(5) + letter_t'(col);
  endfunction

endpackage

// File: design/playfair_pair_cipher_top.sv
// top level of the playfair pair cipher block
// depends on ppc_pkg, ppc_ctrl, ppc_datapath (and through it ppc_ram)

// Playfair cipher over a 5x5 key square held in two small RAMs (letter to position
// and position to letter). Before end of key, a key letter is placed as it is accepted.
// An end-of-key item starts a walk of the 26-letter alphabet, one letter a cycle,
// which fills the free places of the square. A text pair goes through two registered
// RAM reads in sequence (the two positions, then the two square letters); a finished
// result sits in an output register, and the next item is accepted once the pair
// has left the lookup steps and the register is free. The user must write
// decrypt_mode through cfg_we_i/cfg_wdata_i only while the block is idle; the block
// does not enforce this. Before end of key, pairs come back unchanged with status 1.
module playfair_pair_cipher_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         func_i,
  input  ppc_pkg::letter_t   first_letter_i,
  input  ppc_pkg::letter_t   second_letter_i,
  input  logic               second_present_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ppc_pkg::letter_t   first_out_o,
  output ppc_pkg::letter_t   second_out_o,
  output logic               status_o
);
  import ppc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // sequencing
  ppc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // square storage and cipher rules
  ppc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .first_letter_i   (first_letter_i),
    .second_letter_i  (second_letter_i),
    .second_present_i (second_present_i),
    .first_out_o      (first_out_o),
    .second_out_o     (second_out_o),
    .status_o         (status_o)
  );

endmodule

// File: design/ppc_ram.sv
// generic ram, one write port and two registered read ports
// no dependencies
module ppc_ram #(
  parameter int Width = 5,
  parameter int Depth = 25,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr0_i,
  input  logic [AddrW-1:0] raddr1_i,
  output logic [Width-1:0] rdata0_o,
  output logic [Width-1:0] rdata1_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata0_q, rdata1_q;

  // write and registered reads; read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// File: design/ppc_datapath.sv
// datapath: key square build, position and square lookups, output register
// depends on ppc_pkg and ppc_ram
module ppc_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ppc_pkg::ctrl_cmd_t    cmd_i,
  output ppc_pkg::dp_status_t   sts_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  ppc_pkg::letter_t      first_letter_i,
  input  ppc_pkg::letter_t      second_letter_i,
  input  logic                  second_present_i,
  output ppc_pkg::letter_t      first_out_o,
  output ppc_pkg::letter_t      second_out_o,
  output logic                  status_o
);
  import ppc_pkg::*;

  logic [NumLetters-1:0] present_q, present_d;
  letter_t fill_q, fill_d;
  letter_t walk_q, walk_d;
  logic    ready_q, ready_d;
  logic    decrypt_q;
  letter_t raw1_q, raw2_q;
  letter_t out1_q, out2_q;
  logic    status_q;

  letter_t key_letter, place_letter, fold_a, fold_b;
  logic    place_req, place_en;
  letter_t pos_a, pos_b, sq_a, sq_b;
  letter_t sq_addr_a, sq_addr_b;
  coord_t  r1, c1, r2, c2, r1n, c1n, r2n, c2n;

  // letter to be placed: folded key letter or the alphabet walk
  assign key_letter   = fold_letter(first_letter_i);
  assign place_letter = cmd_i.fill_step ? walk_q : key_letter;
  assign place_req    = cmd_i.place_key || (cmd_i.fill_step && (walk_q != LETTER_J));
  assign place_en     = place_req && !present_q[place_letter] && (fill_q < SQUARE_SIZE);

  // pair letters for the position lookup
  assign fold_a = key_letter;
  assign fold_b = second_present_i ? fold_letter(second_letter_i) : LETTER_X;

  // square state and walk counter
  always_comb begin
    present_d = present_q;
    fill_d    = fill_q;
    walk_d    = walk_q;
    ready_d   = ready_q;
    if (place_en) begin
      present_d[place_letter] = 1'b1;
      fill_d = fill_q + 5'd1;
    end
    if (cmd_i.fill_start) walk_d = '0;
    else if (cmd_i.fill_step) walk_d = walk_q + 5'd1;
    if (cmd_i.set_ready) ready_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      fill_q    <= '0;
      walk_q    <= '0;
      ready_q   <= 1'b0;
      decrypt_q <= 1'b0;
    end else begin
      present_q <= present_d;
      fill_q    <= fill_d;
      walk_q    <= walk_d;
      ready_q   <= ready_d;
      if (cfg_we_i) decrypt_q <= cfg_wdata_i;
    end
  end

  // letter to position table
  ppc_ram #(.Width(LetterW), .Depth(NumLetters)) u_pos_ram (
    .clk_i    (clk_i),
    .we_i     (place_en),
    .waddr_i  (place_letter),
    .wdata_i  (fill_q),
    .re_i     (cmd_i.pos_read),
    .raddr0_i (fold_a),
    .raddr1_i (fold_b),
    .rdata0_o (pos_a),
    .rdata1_o (pos_b)
  );

  // playfair rules on the two positions
  always_comb begin
    r1 = pos_row(pos_a);
    c1 = pos_col(pos_a);
    r2 = pos_row(pos_b);
    c2 = pos_col(pos_b);
    if (r1 == r2) begin
      r1n = r1;
      r2n = r2;
      c1n = coord_step(c1, decrypt_q);
      c2n = coord_step(c2, decrypt_q);
    end else if (c1 == c2) begin
      r1n = coord_step(r1, decrypt_q);
      r2n = coord_step(r2, decrypt_q);
      c1n = c1;
      c2n = c2;
    end else begin
      r1n = r1;
      r2n = r2;
      c1n = c2;
      c2n = c1;
    end
  end

  assign sq_addr_a = grid_addr(r1n, c1n);
  assign sq_addr_b = grid_addr(r2n, c2n);

  // key square contents
  ppc_ram #(.Width(LetterW), .Depth(SquareCells)) u_sq_ram (
    .clk_i    (clk_i),
    .we_i     (place_en),
    .waddr_i  (fill_q),
    .wdata_i  (place_letter),
    .re_i     (cmd_i.sq_read),
    .raddr0_i (sq_addr_a),
    .raddr1_i (sq_addr_b),
    .rdata0_o (sq_a),
    .rdata1_o (sq_b)
  );

  // raw pair kept for pass-through and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      raw1_q <= first_letter_i;
      raw2_q <= second_present_i ? second_letter_i : LETTER_X;
    end
    if (cmd_i.load_out) begin
      out1_q   <= ready_q ? sq_a : raw1_q;
      out2_q   <= ready_q ? sq_b : raw2_q;
      status_q <= !ready_q;
    end
  end

  assign sts_o.square_ready = ready_q;
  assign sts_o.fill_last    = (walk_q == LETTER_Z);
  assign first_out_o        = out1_q;
  assign second_out_o       = out2_q;
  assign status_o           = status_q;

endmodule

// File: design/ppc_ctrl.sv
// controller: item decode, fill walk sequencing, pair lookup steps, output valid
// depends on ppc_pkg and the assertion macro header
`include "playfair_pair_cipher_top_macros.svh"

module ppc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ppc_pkg::dp_status_t sts_i,
  output ppc_pkg::ctrl_cmd_t  cmd_o
);
  import ppc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_SQ   = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_xfer;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (func_i)
            FUNC_KEY: begin
              cmd_o.place_key = !sts_i.square_ready;
            end
            FUNC_FILL: begin
              if (!sts_i.square_ready) begin
                cmd_o.fill_start = 1'b1;
                state_d = ST_FILL;
              end
            end
            FUNC_PAIR: begin
              cmd_o.capture  = 1'b1;
              cmd_o.pos_read = 1'b1;
              state_d = ST_SQ;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) begin
          cmd_o.set_ready = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SQ: begin
        cmd_o.sq_read = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid: set on load, cleared on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  `PPC_ASSERT_SAME(a_no_overwrite, clk_i, rst_ni, cmd_o.load_out, !out_valid_q || out_ready_i, "result overwritten before transfer")
  `PPC_ASSERT_NEXT(a_fill_ends_ready, clk_i, rst_ni, (state_q == ST_FILL) && sts_i.fill_last, sts_i.square_ready && (state_q == ST_IDLE), "fill walk ended without ready square")
  `PPC_ASSERT_NEXT(a_ready_sticks, clk_i, rst_ni, sts_i.square_ready, sts_i.square_ready, "square ready dropped")
  `PPC_ASSERT_NEXT(a_pair_lookup, clk_i, rst_ni, state_q == ST_SQ, state_q == ST_DONE, "square lookup step skipped")

endmodule

// File: bench/tb_playfair_pair_cipher_top.sv
// testbench for playfair_pair_cipher_top: key loading, square fill and pair ciphering
// depends on ppc_pkg and the playfair_pair_cipher_top RTL; results checked against a local predictor
module tb_playfair_pair_cipher_top;
  import ppc_pkg::*;

  localparam logic [1:0] FUNC_NONE    = 2'd3;
  localparam int         LongHold     = 300;
  localparam int         SettleCycles = 40;

  typedef struct {
    letter_t first;
    letter_t second;
    logic    stat;
  } cipher_pair_t;

  logic    clk_i            = 1'b0;
  logic    rst_ni           = 1'b0;
  logic    cfg_we_i         = 1'b0;
  logic    cfg_wdata_i      = 1'b0;
  logic    in_valid_i       = 1'b0;
  logic    in_ready_o;
  logic [1:0] func_i        = FUNC_KEY;
  letter_t first_letter_i   = '0;
  letter_t second_letter_i  = '0;
  logic    second_present_i = 1'b0;
  logic    out_valid_o;
  logic    out_ready_i      = 1'b0;
  letter_t first_out_o;
  letter_t second_out_o;
  logic    status_o;

  playfair_pair_cipher_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .first_letter_i   (first_letter_i),
    .second_letter_i  (second_letter_i),
    .second_present_i (second_present_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .first_out_o      (first_out_o),
    .second_out_o     (second_out_o),
    .status_o         (status_o)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predicted square and settings
  letter_t      sq_cell [SquareCells];
  letter_t      sq_pos [NumLetters];
  logic [25:0]  letter_placed = '0;
  int           sq_filled     = 0;
  bit           sq_ready      = 1'b0;
  bit           dec_mode      = 1'b0;
  cipher_pair_t pending_pairs [$];
  int           mismatches    = 0;

  // traffic shaping
  bit tx_gaps      = 1'b0;
  int burst_left   = 0;
  int rx_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int run_left     = 0;
  bit run_ready    = 1'b1;

  // clamp to z, then j folds onto i
  function automatic letter_t fold_code(letter_t v);
    letter_t c;
    c = (v > LETTER_Z) ? LETTER_Z : v;
    if (c == LETTER_J) c = LETTER_I;
    return c;
  endfunction

  function automatic void place_in_square(letter_t c);
    if (sq_filled >= SquareCells || letter_placed[c]) return;
    sq_cell[sq_filled] = c;
    sq_pos[c] = letter_t'(sq_filled);
    letter_placed[c] = 1'b1;
    sq_filled++;
  endfunction

  // advance the predicted state by one accepted item, queue the pair it yields
  function automatic void playfair_step(logic [1:0] f, letter_t a_raw, letter_t b_raw,
                                        logic pres);
    cipher_pair_t res;
    letter_t a, b;
    int pa, pb, r1, c1, r2, c2, step;
    case (f)
      FUNC_KEY: begin
        if (!sq_ready) place_in_square(fold_code(a_raw));
      end
      FUNC_FILL: begin
        if (!sq_ready) begin
          for (int k = 0; k < NumLetters; k++)
            if (letter_t'(k) != LETTER_J) place_in_square(letter_t'(k));
          sq_ready = 1'b1;
        end
      end
      FUNC_PAIR: begin
        if (!sq_ready) begin
          res.first  = a_raw;
          res.second = pres ? b_raw : LETTER_X;
          res.stat   = 1'b1;
        end else begin
          a = fold_code(a_raw);
          b = pres ? fold_code(b_raw) : LETTER_X;
          pa = sq_pos[a];
          pb = sq_pos[b];
          r1 = pa / 5; c1 = pa % 5;
          r2 = pb / 5; c2 = pb % 5;
          step = dec_mode ? 4 : 1;
          if (r1 == r2) begin
            res.first  = sq_cell[r1 * 5 + (c1 + step) % 5];
            res.second = sq_cell[r2 * 5 + (c2 + step) % 5];
          end else if (c1 == c2) begin
            res.first  = sq_cell[((r1 + step) % 5) * 5 + c1];
            res.second = sq_cell[((r2 + step) % 5) * 5 + c2];
          end else begin
            res.first  = sq_cell[r1 * 5 + c2];
            res.second = sq_cell[r2 * 5 + c1];
          end
          res.stat = 1'b0;
        end
        pending_pairs.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // mostly legal codes, sometimes out of range
  function automatic letter_t rand_letter();
    if ($urandom_range(0, 4) == 0) return letter_t'($urandom_range(0, 31));
    return letter_t'($urandom_range(0, 25));
  endfunction

  // random pair biased toward same row, same column and equal letters
  function automatic void pick_pair(output letter_t a, output letter_t b, output logic pres);
    int pa, kind;
    a = rand_letter();
    pa = sq_pos[fold_code(a)];
    kind = $urandom_range(0, 9);
    pres = ($urandom_range(0, 7) != 0);
    if (kind < 3)       b = sq_cell[(pa / 5) * 5 + $urandom_range(0, 4)];
    else if (kind < 6)  b = sq_cell[$urandom_range(0, 4) * 5 + pa % 5];
    else if (kind == 6) b = a;
    else                b = rand_letter();
  endfunction

  // offer one item, wait for the transfer, then pace the sender
  task automatic send_item(logic [1:0] f, letter_t a, letter_t b, logic pres);
    in_valid_i       <= 1'b1;
    func_i           <= f;
    first_letter_i   <= a;
    second_letter_i  <= b;
    second_present_i <= pres;
    do @(posedge clk_i); while (!in_ready_o);
    playfair_step(f, a, b, pres);
    if (tx_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left--;
    end
  endtask

  // stop sending, wait for every pair, then let a fill walk finish
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_pairs.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(bit m);
    settle_idle();
    cfg_wdata_i <= m;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    dec_mode = m;
  endtask

  // receiver: random ready runs, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left = LongHold;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (rx_stall_pct == 0) begin
      out_ready_i <= 1'b1;
    end else begin
      if (run_left == 0) begin
        run_ready = ($urandom_range(0, 99) >= rx_stall_pct);
        run_left  = $urandom_range(1, 8);
      end
      run_left--;
      out_ready_i <= run_ready;
    end
  end

  // compare each result transfer with the oldest predicted pair
  always @(posedge clk_i) begin
    cipher_pair_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pairs.size() == 0) begin
        $error("result with no pair pending: first_out %0d second_out %0d status %0d",
               first_out_o, second_out_o, status_o);
        mismatches++;
      end else begin
        want = pending_pairs.pop_front();
        if (first_out_o !== want.first) begin
          $error("first_out expected %0d actual %0d", want.first, first_out_o);
          mismatches++;
        end
        if (second_out_o !== want.second) begin
          $error("second_out expected %0d actual %0d", want.second, second_out_o);
          mismatches++;
        end
        if (status_o !== want.stat) begin
          $error("status expected %0d actual %0d", want.stat, status_o);
          mismatches++;
        end
      end
    end
  end

  // pairs pass through raw with status set before the key is done
  task automatic test_pairs_before_key();
    tx_gaps = 1'b1;
    rx_stall_pct = 30;
    send_item(FUNC_PAIR, 5'd0, 5'd25, 1'b1);
    send_item(FUNC_PAIR, 5'd31, 5'd30, 1'b1);
    send_item(FUNC_PAIR, 5'd9, 5'd4, 1'b0);
    send_item(FUNC_NONE, 5'd3, 5'd7, 1'b1);
  endtask

  // fixed keyword with j, a repeat and an out-of-range code, then random key letters
  task automatic test_key_load();
    send_item(FUNC_KEY, 5'd15, 5'd0, 1'b0);
    send_item(FUNC_KEY, 5'd11, 5'd0, 1'b0);
    send_item(FUNC_KEY, 5'd0, 5'd0, 1'b0);
    send_item(FUNC_KEY, 5'd9, 5'd0, 1'b0);
    send_item(FUNC_KEY, 5'd8, 5'd0, 1'b0);
    send_item(FUNC_KEY, 5'd31, 5'd0, 1'b0);
    send_item(FUNC_KEY, 5'd0, 5'd0, 1'b0);
    repeat ($urandom_range(0, 15))
      send_item(FUNC_KEY, letter_t'($urandom_range(0, 31)), rand_letter(), 1'($urandom));
  endtask

  // fill the square; late key letters, a second fill and an unused code are ignored
  task automatic test_fill_and_late_key();
    send_item(FUNC_FILL, 5'd0, 5'd0, 1'b0);
    send_item(FUNC_KEY, 5'd25, 5'd0, 1'b0);
    send_item(FUNC_FILL, 5'd12, 5'd3, 1'b1);
    send_item(FUNC_NONE, 5'd31, 5'd31, 1'b0);
  endtask

  // each rule with wrap, equal letters, odd tail, folding and clamping, in both modes
  task automatic test_directed_pairs();
    for (int m = 0; m < 2; m++) begin
      write_mode(1'(m));
      send_item(FUNC_PAIR, sq_cell[0], sq_cell[1], 1'b1);
      send_item(FUNC_PAIR, sq_cell[4], sq_cell[3], 1'b1);
      send_item(FUNC_PAIR, sq_cell[2], sq_cell[22], 1'b1);
      send_item(FUNC_PAIR, sq_cell[6], sq_cell[18], 1'b1);
      send_item(FUNC_PAIR, sq_cell[12], sq_cell[12], 1'b1);
      send_item(FUNC_PAIR, sq_cell[7], 5'd0, 1'b0);
      send_item(FUNC_PAIR, LETTER_J, sq_cell[1], 1'b1);
      send_item(FUNC_PAIR, 5'd31, 5'd30, 1'b1);
    end
  endtask

  // random pairs with some ignored items mixed in
  task automatic run_pairs(int count, bit gaps, int stall_pct);
    letter_t a, b;
    logic pres;
    int sent;
    tx_gaps = gaps;
    rx_stall_pct = stall_pct;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0:       send_item(FUNC_KEY, rand_letter(), rand_letter(), 1'($urandom));
          1:       send_item(FUNC_FILL, rand_letter(), rand_letter(), 1'($urandom));
          default: send_item(FUNC_NONE, rand_letter(), rand_letter(), 1'($urandom));
        endcase
      end else begin
        pick_pair(a, b, pres);
        send_item(FUNC_PAIR, a, b, pres);
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    write_mode(1'b0);
    run_pairs(130, 1'b0, 0);
    write_mode(1'b1);
    run_pairs(170, 1'b1, 35);
    write_mode(1'b1);
    run_pairs(170, 1'b1, 15);
    write_mode(1'b0);
    run_pairs(170, 1'b0, 70);
    write_mode(1'b1);
    run_pairs(50, 1'b1, 0);
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    write_mode(1'b0);
    hold_request = 1'b1;
    run_pairs(40, 1'b0, 0);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_mode(1'b0);
    test_pairs_before_key();
    test_key_load();
    test_fill_and_late_key();
    test_directed_pairs();
    test_random_traffic();
    test_backpressure();
    settle_idle();
    if (mismatches == 0 && pending_pairs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // timeout
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
